FILE: src/cse_pkg.sv
`timescale 1ns / 1ps
package cse_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned MAX_LEN    = 65536;
  localparam int unsigned CNT_W      = $clog2(MAX_LEN + 2);
  localparam int unsigned DOT_W      = 48;
  localparam int unsigned NORM_W     = 47;
  localparam int unsigned LIMB_W     = 24;
  localparam int unsigned PROD_W     = 2 * LIMB_W;
  localparam int unsigned ACC_W      = 2 * PROD_W;
  localparam int unsigned WIDE_W     = 2 * NORM_W - 1;
  localparam int unsigned QUO_W      = 29;
  localparam int unsigned DIV_CNT_W  = $clog2(QUO_W);
  localparam int unsigned ROOT_W     = 15;
  localparam int unsigned ROOT_BIT_W = $clog2(ROOT_W);
  localparam int unsigned SIM_W      = 16;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned SIM_ONE    = 16384;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned WM_STEPS   = 4;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_NORM = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EAB,
    S_EAA,
    S_EBB,
    S_EACC,
    S_CHECK,
    S_WMUL,
    S_DIV,
    S_RT_ISSUE,
    S_RT_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                     valid;
    logic signed [SIM_W-1:0]  similarity;
    status_e                  status;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-2:0] num_hi;
    logic              num_lsb;
    logic [WIDE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/cse_mul.sv
`timescale 1ns / 1ps
module cse_mul (
  input  logic                      clk_i,
  input  logic [cse_pkg::LIMB_W-1:0] a_i,
  input  logic [cse_pkg::LIMB_W-1:0] b_i,
  output logic [cse_pkg::PROD_W-1:0] p_o
);
  import cse_pkg::*;

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: src/cse_div.sv
`timescale 1ns / 1ps
module cse_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cse_pkg::div_req_t req_i,
  output cse_pkg::div_rsp_t rsp_o
);
  import cse_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 nbit_q, nbit_d;
  logic [WIDE_W-1:0]    rem_q, rem_d;
  logic [WIDE_W-1:0]    den_q, den_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [WIDE_W:0]      trial;
  logic [WIDE_W+1:0]    diff;

  // remainder always stays below the divisor, so one compare-subtract per bit
  assign trial = {rem_q, nbit_q};
  assign diff  = {1'b0, trial} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nbit_d = nbit_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(QUO_W - 1);
      nbit_d = req_i.num_lsb;
      rem_d  = {1'b0, req_i.num_hi};
      den_d  = req_i.den;
      quo_d  = '0;
    end else if (busy_q) begin
      nbit_d = 1'b0;
      if (!diff[WIDE_W+1]) begin
        rem_d = diff[WIDE_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = trial[WIDE_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nbit_q <= nbit_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: src/cse_core.sv
`timescale 1ns / 1ps
module cse_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cse_pkg::DATA_W-1:0]  elem_a_i,
  input  logic signed [cse_pkg::DATA_W-1:0]  elem_b_i,
  input  logic                               last_elem_i,
  input  logic                               out_free_i,
  output cse_pkg::res_t                      res_o,
  output logic [cse_pkg::LIMB_W-1:0]         mul_a_o,
  output logic [cse_pkg::LIMB_W-1:0]         mul_b_o,
  input  logic [cse_pkg::PROD_W-1:0]         prod_i,
  output cse_pkg::div_req_t                  div_req_o,
  input  cse_pkg::div_rsp_t                  div_rsp_i
);
  import cse_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt  = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] OverCnt = CNT_W'(MAX_LEN + 1);

  state_e               state_q, state_d;
  status_e              status_q, status_d;
  logic [DOT_W-1:0]     dot_q, dot_d;
  logic [NORM_W-1:0]    na_q, na_d;
  logic [NORM_W-1:0]    nb_q, nb_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0]    a_mag_q, a_mag_d;
  logic [DATA_W-1:0]    b_mag_q, b_mag_d;
  logic                 neg_q, neg_d;
  logic                 last_q, last_d;
  logic                 add_q, add_d;
  logic                 wm_sel_q, wm_sel_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [WIDE_W-1:0]    sq_q, sq_d;
  logic [QUO_W-1:0]     rad_q, rad_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  logic [ROOT_BIT_W-1:0] rbit_q, rbit_d;

  logic [DATA_W-1:0]    a_mag, b_mag;
  logic [DOT_W-1:0]     dot_mag;
  logic [PROD_W-1:0]    wm_x, wm_y;
  logic [1:0]           prev_step;
  logic [1:0]           shift_sel;
  logic [ACC_W-1:0]     acc_add, acc_sum;
  logic [ROOT_W-1:0]    cand;
  logic [ROOT_W-1:0]    sim_mag;
  logic [SIM_W-1:0]     sim_val;

  assign a_mag   = elem_a_i[DATA_W-1] ? (~elem_a_i + 1'b1) : elem_a_i;
  assign b_mag   = elem_b_i[DATA_W-1] ? (~elem_b_i + 1'b1) : elem_b_i;
  assign dot_mag = dot_q[DOT_W-1] ? (~dot_q + 1'b1) : dot_q;

  assign wm_x = wm_sel_q ? {1'b0, na_q} : {1'b0, dot_mag[NORM_W-1:0]};
  assign wm_y = wm_sel_q ? {1'b0, nb_q} : {1'b0, dot_mag[NORM_W-1:0]};

  // product in flight belongs to the previous step: limb weights add up
  assign prev_step = step_q[1:0] - 2'd1;
  assign shift_sel = {1'b0, prev_step[1]} + {1'b0, prev_step[0]};

  always_comb begin
    case (shift_sel)
      2'd0:    acc_add = ACC_W'(prod_i);
      2'd1:    acc_add = ACC_W'(prod_i) << LIMB_W;
      default: acc_add = ACC_W'(prod_i) << (2 * LIMB_W);
    endcase
  end

  assign acc_sum = acc_q + acc_add;
  assign cand    = root_q | (ROOT_W'(1) << rbit_q);

  assign sim_mag = (root_q > ROOT_W'(SIM_ONE)) ? ROOT_W'(SIM_ONE) : root_q;
  assign sim_val = dot_q[DOT_W-1] ? (~SIM_W'(sim_mag) + 1'b1) : SIM_W'(sim_mag);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    dot_d     = dot_q;
    na_d      = na_q;
    nb_d      = nb_q;
    cnt_d     = cnt_q;
    a_mag_d   = a_mag_q;
    b_mag_d   = b_mag_q;
    neg_d     = neg_q;
    last_d    = last_q;
    add_d     = add_q;
    wm_sel_d  = wm_sel_q;
    step_d    = step_q;
    acc_d     = acc_q;
    sq_d      = sq_q;
    rad_d     = rad_q;
    root_d    = root_q;
    rbit_d    = rbit_q;
    mul_a_o   = '0;
    mul_b_o   = '0;
    div_req_o = '0;
    res_o.valid      = 1'b0;
    res_o.similarity = (status_q == ST_OK) ? sim_val : '0;
    res_o.status     = status_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          a_mag_d = a_mag;
          b_mag_d = b_mag;
          neg_d   = elem_a_i[DATA_W-1] ^ elem_b_i[DATA_W-1];
          last_d  = last_elem_i;
          add_d   = (cnt_q < MaxCnt);
          cnt_d   = (cnt_q < MaxCnt) ? cnt_q + 1'b1 : OverCnt;
          state_d = S_EAB;
        end
      end
      S_EAB: begin
        mul_a_o = LIMB_W'(a_mag_q);
        mul_b_o = LIMB_W'(b_mag_q);
        state_d = S_EAA;
      end
      S_EAA: begin
        mul_a_o = LIMB_W'(a_mag_q);
        mul_b_o = LIMB_W'(a_mag_q);
        if (add_q) begin
          dot_d = neg_q ? dot_q - DOT_W'(prod_i) : dot_q + DOT_W'(prod_i);
        end
        state_d = S_EBB;
      end
      S_EBB: begin
        mul_a_o = LIMB_W'(b_mag_q);
        mul_b_o = LIMB_W'(b_mag_q);
        if (add_q) begin
          na_d = na_q + prod_i[NORM_W-1:0];
        end
        state_d = S_EACC;
      end
      S_EACC: begin
        if (add_q) begin
          nb_d = nb_q + prod_i[NORM_W-1:0];
        end
        state_d = last_q ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (cnt_q > MaxCnt) begin
          status_d = ST_TOO_LONG;
          state_d  = S_DONE;
        end else if (na_q == '0 || nb_q == '0) begin
          status_d = ST_ZERO_NORM;
          state_d  = S_DONE;
        end else begin
          status_d = ST_OK;
          wm_sel_d = 1'b0;
          step_d   = '0;
          acc_d    = '0;
          state_d  = S_WMUL;
        end
      end
      S_WMUL: begin
        // square of the dot magnitude, then the product of the two norms
        if (step_q != STEP_W'(WM_STEPS)) begin
          mul_a_o = step_q[1] ? wm_x[PROD_W-1:LIMB_W] : wm_x[LIMB_W-1:0];
          mul_b_o = step_q[0] ? wm_y[PROD_W-1:LIMB_W] : wm_y[LIMB_W-1:0];
        end
        if (step_q != '0) begin
          acc_d = acc_sum;
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(WM_STEPS)) begin
          step_d = '0;
          acc_d  = '0;
          if (!wm_sel_q) begin
            sq_d     = acc_sum[WIDE_W-1:0];
            wm_sel_d = 1'b1;
          end else begin
            div_req_o.start   = 1'b1;
            div_req_o.num_hi  = sq_q[WIDE_W-1:1];
            div_req_o.num_lsb = sq_q[0];
            div_req_o.den     = acc_sum[WIDE_W-1:0];
            state_d           = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          rad_d   = div_rsp_i.quotient;
          root_d  = '0;
          rbit_d  = ROOT_BIT_W'(ROOT_W - 1);
          state_d = S_RT_ISSUE;
        end
      end
      S_RT_ISSUE: begin
        mul_a_o = LIMB_W'(cand);
        mul_b_o = LIMB_W'(cand);
        state_d = S_RT_CMP;
      end
      S_RT_CMP: begin
        if (prod_i <= PROD_W'(rad_q)) begin
          root_d = cand;
        end
        if (rbit_q == '0) begin
          state_d = S_DONE;
        end else begin
          rbit_d  = rbit_q - 1'b1;
          state_d = S_RT_ISSUE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the item, then clear sums
        if (out_free_i) begin
          res_o.valid = 1'b1;
          dot_d       = '0;
          na_d        = '0;
          nb_d        = '0;
          cnt_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
      dot_q    <= '0;
      na_q     <= '0;
      nb_q     <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      add_q    <= 1'b0;
      wm_sel_q <= 1'b0;
      step_q   <= '0;
      rbit_q   <= '0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      dot_q    <= dot_d;
      na_q     <= na_d;
      nb_q     <= nb_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      add_q    <= add_d;
      wm_sel_q <= wm_sel_d;
      step_q   <= step_d;
      rbit_q   <= rbit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mag_q <= a_mag_d;
    b_mag_q <= b_mag_d;
    neg_q   <= neg_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    rad_q   <= rad_d;
    root_q  <= root_d;
  end

  a_res_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> out_free_i)
    else $error("result issued while output register is full");

  a_status_zero_sim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status != ST_OK |-> res_o.similarity == '0)
    else $error("nonzero similarity with error status");

  a_sim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ($signed(res_o.similarity) <= $signed(SIM_W'(SIM_ONE)) &&
                     $signed(res_o.similarity) >= -$signed(SIM_W'(SIM_ONE))))
    else $error("similarity outside +/-1.0");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> div_rsp_i.quotient <= (QUO_W'(1) << (QUO_W - 1)))
    else $error("squared ratio above one");

  a_clear_after_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> cnt_q == '0 && dot_q == '0 && na_q == '0 && nb_q == '0)
    else $error("sums not cleared after result");

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OverCnt)
    else $error("element count past saturation");

endmodule

FILE: src/cosine_similarity_engine.sv
`timescale 1ns / 1ps
// Streaming cosine similarity of two signed 16-bit vectors.
// Slave channel: one element pair per item, A in tdata[15:0], B in tdata[31:16],
// tlast on the final pair. Master channel: one item per vector, the similarity
// in signed Q2.14 on tdata (16384 = 1.0) and a status code on tuser
// (0 ok, 1 a norm was zero, 2 more than MAX_LEN elements, result then 0).
// Each pair is taken in the accept state and then passes EAB, EAA, EBB and
// EACC, which issue a*b, a*a and b*b to the single shared 24x24 multiplier
// and add up the products; tready is low meanwhile. After a last pair the
// same multiplier forms dot^2 and normA*normB from 24-bit limbs, a restoring
// divider yields dot^2*2^28/(normA*normB) one bit a cycle, and a bit-serial
// square root on the multiplier forms the result from that quotient.
// The result sits in an output register; pairs of the next vector are taken
// while it waits. If the receiver still holds the previous result when a new
// one is ready, the engine waits with tready low until tready on the master
// side frees the register.
// Reset clears the sums, the element count and the output valid.
module cosine_similarity_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic        s_axis_tlast,   // last_elem
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] similarity
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import cse_pkg::*;

  logic                  out_free;
  res_t                  res;
  logic [LIMB_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]     prod;
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic                  m_valid_q, m_valid_d;
  logic [SIM_W-1:0]      sim_q;
  logic [STAT_W-1:0]     stat_q;

  assign out_free = !m_valid_q || m_axis_tready;

  cse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .elem_a_i    ($signed(s_axis_tdata[DATA_W-1:0])),
    .elem_b_i    ($signed(s_axis_tdata[2*DATA_W-1:DATA_W])),
    .last_elem_i (s_axis_tlast),
    .out_free_i  (out_free),
    .res_o       (res),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .prod_i      (prod),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  cse_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  cse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (res.valid) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      sim_q  <= res.similarity;
      stat_q <= res.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = sim_q;
  assign m_axis_tuser  = stat_q;

endmodule

FILE: bench/cosine_similarity_engine_test.sv
`timescale 1ns / 1ps
module cosine_similarity_engine_test;
  import cse_pkg::*;

  typedef enum int {
    PH_DIRECT,
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } phase_e;

  typedef struct packed {
    logic [15:0] sim;
    status_e     st;
  } cos_result_t;

  typedef struct packed {
    logic [15:0] elem_a;
    logic [15:0] elem_b;
    int unsigned count;
    logic        last;
    logic        pinned;
    logic [15:0] sim;
    status_e     st;
  } dir_row_t;

  localparam int unsigned ROWS       = 21;
  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned HOLD_CYCLES = 600;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // running sums of the vector being received
  logic signed [47:0] run_dot   = '0;
  logic [46:0]        run_na    = '0;
  logic [46:0]        run_nb    = '0;
  logic [16:0]        run_count = '0;

  cos_result_t pending_cos[$];
  cos_result_t oldest_cos;
  int unsigned mismatches = 0;
  phase_e      phase      = PH_DIRECT;
  phase_e      seen_phase = PH_DIRECT;
  int unsigned hold_left  = 0;

  // pinned rows carry a result that follows directly from the inputs
  dir_row_t dir_rows [ROWS] = '{
    '{16'h0001, 16'h0001, 1, 1'b1, 1'b1, 16'h4000, ST_OK},
    '{16'h8000, 16'h8000, 1, 1'b1, 1'b1, 16'h4000, ST_OK},
    '{16'h7FFF, 16'h8000, 1, 1'b1, 1'b1, 16'hC000, ST_OK},
    '{16'h8000, 16'h7FFF, 1, 1'b1, 1'b1, 16'hC000, ST_OK},
    '{16'h0000, 16'h0005, 1, 1'b1, 1'b1, 16'h0000, ST_ZERO_NORM},
    '{16'hFFF9, 16'h0000, 1, 1'b1, 1'b1, 16'h0000, ST_ZERO_NORM},
    '{16'h0000, 16'h0000, 1, 1'b1, 1'b1, 16'h0000, ST_ZERO_NORM},
    '{16'h0001, 16'h0000, 1, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{16'h0000, 16'h0001, 1, 1'b1, 1'b1, 16'h0000, ST_OK},
    '{16'h0064, 16'h00C8, 1, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{16'hFED4, 16'h0032, 1, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{16'h0007, 16'hFFF7, 1, 1'b1, 1'b0, 16'h0000, ST_OK},
    '{16'h5555, 16'hAAAA, 1, 1'b1, 1'b0, 16'h0000, ST_OK},
    '{16'h7FFF, 16'h7FFF, 3, 1'b1, 1'b1, 16'h4000, ST_OK},
    '{16'h3039, 16'h8000, 1, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{16'hFFFF, 16'h7FFF, 1, 1'b1, 1'b0, 16'h0000, ST_OK},
    '{16'h8000, 16'h8000, 65536, 1'b1, 1'b1, 16'h4000, ST_OK},
    // too long wins over a zero norm
    '{16'h0000, 16'h7FFF, 65537, 1'b1, 1'b1, 16'h0000, ST_TOO_LONG},
    '{16'h0003, 16'h0004, 1, 1'b1, 1'b1, 16'h4000, ST_OK},
    '{16'h0002, 16'hFFFD, 1, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{16'h0005, 16'h0001, 1, 1'b1, 1'b0, 16'h0000, ST_OK}
  };

  cosine_similarity_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // largest q with q*q*na*nb <= dot*dot*2^28, signed like dot, clamped to 1.0
  function automatic logic [15:0] q14_cosine(input logic signed [47:0] dot,
                                             input logic [46:0] na,
                                             input logic [46:0] nb);
    logic [47:0]  mag48;
    logic [127:0] mag, rhs, prod, cand, lhs;
    logic [14:0]  q;
    logic [15:0]  mag_q;
    mag48 = dot[47] ? 48'(-dot) : 48'(dot);
    mag   = {80'd0, mag48};
    rhs   = (mag * mag) << 28;
    prod  = {81'd0, na} * {81'd0, nb};
    q     = '0;
    for (int bit_i = 14; bit_i >= 0; bit_i--) begin
      cand = {113'd0, q | 15'(1 << bit_i)};
      lhs  = prod * cand * cand;
      if (lhs <= rhs) q = cand[14:0];
    end
    if (q > 15'(SIM_ONE)) q = 15'(SIM_ONE);
    mag_q = {1'b0, q};
    return dot[47] ? 16'(-mag_q) : mag_q;
  endfunction

  task automatic fold_pair(input logic [15:0] a, input logic [15:0] b, input logic last,
                           output bit emitted, output cos_result_t res);
    logic signed [47:0] ax, bx;
    ax = {{32{a[15]}}, a};
    bx = {{32{b[15]}}, b};
    if (run_count < 17'(MAX_LEN)) begin
      run_dot   = run_dot + ax * bx;
      run_na    = run_na + 47'(ax * ax);
      run_nb    = run_nb + 47'(bx * bx);
      run_count = run_count + 17'd1;
    end else begin
      run_count = 17'(MAX_LEN + 1);
    end
    emitted = last;
    res     = '{sim: 16'd0, st: ST_OK};
    if (last) begin
      if (run_count > 17'(MAX_LEN)) res.st = ST_TOO_LONG;
      else if (run_na == '0 || run_nb == '0) res.st = ST_ZERO_NORM;
      else res.sim = q14_cosine(run_dot, run_na, run_nb);
      run_dot   = '0;
      run_na    = '0;
      run_nb    = '0;
      run_count = '0;
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_pair(input logic [15:0] a, input logic [15:0] b, input logic last,
                            input logic pinned, input cos_result_t pinned_res);
    int unsigned idle_pct;
    bit          emitted;
    cos_result_t res;
    case (phase)
      PH_SEND_IDLE: idle_pct = 72;
      PH_BOTH:      idle_pct = 36;
      default:      idle_pct = 0;
    endcase
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    fold_pair(a, b, last, emitted, res);
    if (emitted) pending_cos.push_back(pinned ? pinned_res : res);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4:    return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom());
    endcase
  endfunction

  // receiver: random stalls per phase, one long hold-off when the free phase opens
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (phase != seen_phase) begin
        seen_phase = phase;
        if (phase == PH_FREE) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case (phase)
          PH_RECV_STALL: m_axis_tready <= ($urandom_range(0, 99) >= 72);
          PH_BOTH:       m_axis_tready <= ($urandom_range(0, 99) >= 36);
          default:       m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cos.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: similarity %0d status %0d",
                   $signed(m_axis_tdata), m_axis_tuser);
        mismatches++;
      end else begin
        oldest_cos = pending_cos.pop_front();
        if (m_axis_tdata !== oldest_cos.sim || m_axis_tuser !== oldest_cos.st) begin
          if (mismatches < 10)
            $display("mismatch: similarity %0d status %0d, expected %0d status %0d",
                     $signed(m_axis_tdata), m_axis_tuser,
                     $signed(oldest_cos.sim), oldest_cos.st);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned sent, len, mode;
    logic [15:0] a, b;
    cos_result_t pin;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      pin = '{sim: dir_rows[r].sim, st: dir_rows[r].st};
      for (int unsigned k = 0; k < dir_rows[r].count; k++)
        offer_pair(dir_rows[r].elem_a, dir_rows[r].elem_b,
                   dir_rows[r].last && (k == dir_rows[r].count - 1),
                   dir_rows[r].pinned, pin);
    end

    for (int p = PH_FREE; p <= PH_BOTH; p++) begin
      phase = phase_e'(p);
      sent  = 0;
      while (sent < PHASE_ITEMS) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        mode = $urandom_range(0, 6);
        for (int unsigned k = 0; k < len; k++) begin
          a = pick_elem();
          case (mode)
            3:       b = a;
            4:       b = -a;
            5:       b = a + 16'($urandom_range(0, 6)) - 16'd3;
            6: begin
              a = 16'h0000;
              b = pick_elem();
            end
            default: b = pick_elem();
          endcase
          offer_pair(a, b, k == len - 1, 1'b0, '0);
        end
        sent += len;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_cos.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cse_pkg.sv
src/cse_mul.sv
src/cse_div.sv
src/cse_core.sv
src/cosine_similarity_engine.sv
bench/cosine_similarity_engine_test.sv
